@@ rtl/hkta_pkg.sv @@
package hkta_pkg;

   localparam logic [7:0] KEY_A     = 8'h04;
   localparam logic [7:0] KEY_Z     = 8'h1D;
   localparam logic [7:0] KEY_1     = 8'h1E;
   localparam logic [7:0] KEY_0     = 8'h27;
   localparam logic [7:0] KEY_ENTER = 8'h28;
   localparam logic [7:0] KEY_SLASH = 8'h38;
   localparam logic [7:0] KEY_CAPS  = 8'h39;
   localparam logic [7:0] KEY_RIGHT = 8'h4F;
   localparam logic [7:0] KEY_UP    = 8'h52;
   localparam logic [7:0] KEY_C     = 8'h06;

   localparam logic [7:0] MOD_SHIFT = 8'h22;
   localparam logic [7:0] MOD_CTRL  = 8'h11;

   localparam logic [7:0] CH_ETX     = 8'h03;
   localparam logic [7:0] CH_ESC     = 8'h1B;
   localparam logic [7:0] CH_BRACKET = 8'h5B;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_UPPER_A = 8'h41;

   // Report byte positions.
   localparam logic [1:0] POS_MODIFIER = 2'd0;
   localparam logic [1:0] POS_RESERVED = 2'd1;
   localparam logic [1:0] POS_KEY      = 2'd2;

   // Register index of raw_mode.
   localparam logic REG_RAW_MODE = 1'b0;

   // One run of zero to three characters caused by one report byte.
   // chars[0] goes out first.
   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] chars;
   } run_type;

   function automatic logic [7:0] digit_char(input logic [3:0] idx, input logic shift);
      logic [7:0] c;
      c = 8'h00;
      case (idx)
         4'd0: c = shift ? 8'h21 : 8'h31;
         4'd1: c = shift ? 8'h40 : 8'h32;
         4'd2: c = shift ? 8'h23 : 8'h33;
         4'd3: c = shift ? 8'h24 : 8'h34;
         4'd4: c = shift ? 8'h25 : 8'h35;
         4'd5: c = shift ? 8'h5E : 8'h36;
         4'd6: c = shift ? 8'h26 : 8'h37;
         4'd7: c = shift ? 8'h2A : 8'h38;
         4'd8: c = shift ? 8'h28 : 8'h39;
         4'd9: c = shift ? 8'h29 : 8'h30;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Zero means the key gives no character.
   function automatic logic [7:0] symbol_char(input logic [4:0] idx, input logic shift);
      logic [7:0] c;
      c = 8'h00;
      case (idx)
         5'd0:  c = shift ? 8'h0D : 8'h0A;
         5'd1:  c = CH_ESC;
         5'd2:  c = shift ? 8'h7F : 8'h08;
         5'd3:  c = 8'h09;
         5'd4:  c = 8'h20;
         5'd5:  c = shift ? 8'h5F : 8'h2D;
         5'd6:  c = shift ? 8'h2B : 8'h3D;
         5'd7:  c = shift ? 8'h7B : 8'h5B;
         5'd8:  c = shift ? 8'h7D : 8'h5D;
         5'd9:  c = shift ? 8'h7C : 8'h5C;
         5'd11: c = shift ? 8'h3A : 8'h3B;
         5'd12: c = shift ? 8'h22 : 8'h27;
         5'd13: c = shift ? 8'h7E : 8'h60;
         5'd14: c = shift ? 8'h3C : 8'h2C;
         5'd15: c = shift ? 8'h3E : 8'h2E;
         5'd16: c = shift ? 8'h3F : 8'h2F;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] arrow_char(input logic [1:0] idx);
      logic [7:0] c;
      c = 8'h00;
      case (idx)
         2'd0: c = 8'h43;
         2'd1: c = 8'h44;
         2'd2: c = 8'h42;
         default: c = 8'h41;
      endcase
      return c;
   endfunction

   // Caps lock itself is handled by the caller; here it gives no run.
   function automatic run_type translate_key(input logic [7:0] key, input logic [7:0] mods,
                                             input logic caps);
      run_type    r;
      logic       shift;
      logic       ctrl;
      logic [7:0] c;
      logic [7:0] ofs;
      r.count = 2'd0;
      r.chars = '0;
      shift = |(mods & MOD_SHIFT);
      ctrl = |(mods & MOD_CTRL);
      c = 8'h00;
      ofs = 8'h00;
      if (key == KEY_CAPS) begin
         r.count = 2'd0;
      end else if (ctrl) begin
         if (key == KEY_C) begin
            r.count = 2'd1;
            r.chars[0] = CH_ETX;
         end
      end else if (key >= KEY_A && key <= KEY_Z) begin
         ofs = key - KEY_A;
         r.count = 2'd1;
         r.chars[0] = ((shift == caps) ? CH_LOWER_A : CH_UPPER_A) + ofs;
      end else if (key >= KEY_1 && key <= KEY_0) begin
         ofs = key - KEY_1;
         r.count = 2'd1;
         r.chars[0] = digit_char(ofs[3:0], shift);
      end else if (key >= KEY_ENTER && key <= KEY_SLASH) begin
         ofs = key - KEY_ENTER;
         c = symbol_char(ofs[4:0], shift);
         if (c != 8'h00) begin
            r.count = 2'd1;
            r.chars[0] = c;
         end
      end else if (key >= KEY_RIGHT && key <= KEY_UP) begin
         ofs = key - KEY_RIGHT;
         r.count = 2'd3;
         r.chars[0] = CH_ESC;
         r.chars[1] = CH_BRACKET;
         r.chars[2] = arrow_char(ofs[1:0]);
      end
      return r;
   endfunction

endpackage

@@ rtl/hkta_front.sv @@
module hkta_front import hkta_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       raw_mode,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_byte,
   input  logic       in_first,
   output logic       push_valid,
   input  logic       push_ready,
   output run_type    push_run
);

   logic [7:0] modifier_ff, modifier_in;
   logic [1:0] pos_ff, pos_in;
   logic       caps_ff, caps_in;
   logic [1:0] pos_eff;
   logic       accept;
   run_type    run;

   // The queue must have room before a byte is taken, whatever it yields.
   assign in_ready = push_ready;
   assign accept = in_valid && in_ready;

   always_comb begin
      pos_eff = in_first ? POS_MODIFIER : pos_ff;
      if (pos_eff > POS_KEY) begin
         pos_eff = POS_KEY;
      end
      pos_in = pos_ff;
      modifier_in = modifier_ff;
      caps_in = caps_ff;
      run.count = 2'd0;
      run.chars = '0;
      if (raw_mode) begin
         run.count = 2'd1;
         run.chars[0] = in_byte;
      end else if (pos_eff == POS_MODIFIER) begin
         modifier_in = in_byte;
      end else if (pos_eff == POS_KEY) begin
         run = translate_key(in_byte, modifier_ff, caps_ff);
         if (in_byte == KEY_CAPS) begin
            caps_in = ~caps_ff;
         end
      end
      if (accept) begin
         pos_in = (pos_eff < POS_KEY) ? pos_eff + 2'd1 : POS_KEY;
      end else begin
         modifier_in = modifier_ff;
         caps_in = caps_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modifier_ff <= '0;
         pos_ff <= POS_MODIFIER;
         caps_ff <= 1'b0;
      end else begin
         modifier_ff <= modifier_in;
         pos_ff <= pos_in;
         caps_ff <= caps_in;
      end
   end

   assign push_valid = accept && (run.count != 2'd0);
   assign push_run = run;

endmodule

@@ rtl/hkta_queue.sv @@
module hkta_queue import hkta_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  run_type push_run,
   output logic    pop_valid,
   input  logic    pop_ready,
   output run_type pop_run
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   run_type            entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_run = entries_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_run;
      end
   end

endmodule

@@ rtl/hkta_back.sv @@
module hkta_back import hkta_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       pop_valid,
   output logic       pop_ready,
   input  run_type    pop_run,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] out_char,
   output logic       out_last
);

   logic [1:0] idx_ff, idx_in;
   logic       sent;

   assign out_valid = pop_valid;
   assign out_last = (idx_ff == pop_run.count - 2'd1);
   assign sent = out_valid && out_ready;
   // The head run leaves the queue with its final character.
   assign pop_ready = out_ready && out_last;

   always_comb begin
      case (idx_ff)
         2'd0:    out_char = pop_run.chars[0];
         2'd1:    out_char = pop_run.chars[1];
         default: out_char = pop_run.chars[2];
      endcase
      idx_in = idx_ff;
      if (sent) begin
         idx_in = out_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

@@ rtl/hid_keycode_to_ascii.sv @@
// HID boot keyboard report to terminal character stream.
//
// The req_ channel takes one report byte per transaction; req_tuser marks
// the modifier byte that starts a report. The rsp_ channel gives the
// characters, with rsp_tlast on the final character caused by one byte.
// raw_mode is written through the csr_ port at byte address 0.
//
// A byte is classified in the cycle it is accepted and its zero to three
// characters are queued as one registered run; rsp_ serves the queue head.
// One byte is accepted per cycle while the run queue has room, and one
// character leaves per cycle while rsp_tready is high; an arrow key gives
// three characters. The run queue holds QUEUE_DEPTH runs, which lets input
// bytes be taken while the receiver stalls; req_tready drops only if full.
//
// Reset clears the modifier mask, caps lock, report position, raw_mode and
// the queue. Bytes are never dropped while rsp_tready is low.
module hid_keycode_to_ascii import hkta_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] report_byte
   input  logic        req_tuser,   // [0] first_of_report
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_char
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic    raw_mode_ff, raw_mode_in;
   logic    push_valid, push_ready;
   run_type push_run;
   logic    pop_valid, pop_ready;
   run_type pop_run;

   assign csr_pready = 1'b1;

   always_comb begin
      raw_mode_in = raw_mode_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready
          && csr_paddr[2] == REG_RAW_MODE) begin
         raw_mode_in = csr_pwdata[0];
      end
      csr_prdata = '0;
      if (csr_paddr[2] == REG_RAW_MODE) begin
         csr_prdata = {31'd0, raw_mode_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_mode_ff <= 1'b0;
      end else begin
         raw_mode_ff <= raw_mode_in;
      end
   end

   hkta_front u_front (
      .clock      (clock),
      .reset      (reset),
      .raw_mode   (raw_mode_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_first   (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_run   (push_run)
   );

   hkta_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_run   (push_run),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_run    (pop_run)
   );

   hkta_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_run   (pop_run),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

   // Nothing is offered right after reset.
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // Runs without characters never reach the queue.
   a_no_empty_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pop_run.count != 2'd0)
      else $error("empty run at queue head");

   // The final character of a run releases its queue entry.
   a_last_pops: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |-> pop_valid && pop_ready)
      else $error("run not popped on last character");

endmodule
